// ===== sv/binned_2d_mean_stderr_defines.svh =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BINNED_2D_MEAN_STDERR_DEFINES_SVH
`define BINNED_2D_MEAN_STDERR_DEFINES_SVH

// same-cycle implication, quiet in reset
`define B2MS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet in reset
`define B2MS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/b2ms_pkg.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - package
// Widths, command codes and the structs passed between the units.
// ----------------------------------------------------------------------------
package b2ms_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 6;
  localparam int BINS_W      = 7;
  localparam int OUT_W       = 24;
  localparam int CNT_W       = 13;
  localparam int ADDR_W      = 12;
  localparam int MAX_SAMPLES = 4096;
  localparam logic [BINS_W-1:0] MAX_BINS   = 7'd64;
  localparam logic [BINS_W-1:0] BINS_RESET = 7'd32;

  localparam int DIV_NUM_W = 72;
  localparam int DIV_DEN_W = 39;
  localparam int DIV_CNT_W = 7;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              op;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== sv/b2ms_ifs.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface b2ms_req_if import b2ms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [SAMPLE_W-1:0] x_value;
  logic [SAMPLE_W-1:0] y_value;
  logic [SAMPLE_W-1:0] z_value;
  logic [IDX_W-1:0]    bin_row;
  logic [IDX_W-1:0]    bin_col;

  modport source (output valid, cmd, x_value, y_value, z_value, bin_row, bin_col,
                  input ready);
  modport sink (input valid, cmd, x_value, y_value, z_value, bin_row, bin_col,
                output ready);
endinterface

interface b2ms_rsp_if import b2ms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] center_x;
  logic [OUT_W-1:0] center_y;
  logic [CNT_W-1:0] entry_count;
  logic [OUT_W-1:0] mean_z;
  logic             mean_valid;
  logic [OUT_W-1:0] std_error;
  logic             std_error_valid;
  logic             samples_dropped;

  modport source (output valid, center_x, center_y, entry_count, mean_z, mean_valid,
                  std_error, std_error_valid, samples_dropped, input ready);
  modport sink (input valid, center_x, center_y, entry_count, mean_z, mean_valid,
                std_error, std_error_valid, samples_dropped, output ready);
endinterface

interface b2ms_cfg_if import b2ms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BINS_W-1:0] bins_per_dim;

  modport source (output valid, bins_per_dim, input ready);
  modport sink (input valid, bins_per_dim, output ready);
endinterface

// ===== sv/b2ms_front.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - front end
// Takes requests, decodes the command and queues the work.
// ----------------------------------------------------------------------------
module b2ms_front import b2ms_pkg::*; (
  b2ms_req_if.sink req,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_entry
);

  logic keep;

  always_comb begin
    unique case (cmd_t'(req.cmd))
      CMD_LOAD, CMD_QUERY, CMD_CLEAR: keep = 1'b1;
      default:                        keep = 1'b0;
    endcase
  end

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full && keep;

  assign push_entry.op  = cmd_t'(req.cmd);
  assign push_entry.x   = req.x_value;
  assign push_entry.y   = req.y_value;
  assign push_entry.z   = req.z_value;
  assign push_entry.row = req.bin_row;
  assign push_entry.col = req.bin_col;

endmodule

// ===== sv/b2ms_queue.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - request queue
// Four-entry queue between front end and execution unit.
// ----------------------------------------------------------------------------
module b2ms_queue import b2ms_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = 2;

  entry_t        slots [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== sv/b2ms_div.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - divider
// Restoring divider, one quotient bit a cycle; numerator left-aligned.
// ----------------------------------------------------------------------------
module b2ms_div import b2ms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] acc;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign rem_sh = {rem, acc[DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= req.num;
      rem   <= '0;
      den_r <= req.den;
    end else if (busy) begin
      acc <= {acc[DIV_NUM_W-2:0], ge};
      rem <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = acc;

endmodule

// ===== sv/b2ms_back.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - execution unit
// Sample store, binning pass, per-bin sums and the query arithmetic.
// ----------------------------------------------------------------------------
module b2ms_back import b2ms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BINS_W-1:0] cfg_data,
  input  logic              q_empty,
  input  entry_t            head,
  output logic              pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  b2ms_rsp_if.source        rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_BINIT, S_CLR, S_SRD, S_SOFF, S_SDIV, S_SIDX, S_SBR, S_SBW,
    S_QADDR, S_QRD, S_QDAT, S_QCX, S_QCY, S_QMEAN, S_QM1, S_QM2, S_QM3,
    S_QM4, S_QM5, S_QSE, S_QSQ, S_QOUT
  } state_t;

  state_t state;

  // memories
  logic [47:0] store_mem [MAX_SAMPLES];
  logic [12:0] cnt_mem   [MAX_SAMPLES];
  logic [27:0] sum_mem   [MAX_SAMPLES];
  logic [42:0] sq_mem    [MAX_SAMPLES];
  logic [47:0] rd_s;
  logic [12:0] rd_cnt;
  logic [27:0] rd_sum;
  logic [42:0] rd_sq;

  // control and data registers
  logic [BINS_W-1:0]          bins_reg;
  logic [BINS_W-1:0]          b_used;
  logic [CNT_W-1:0]           bb;
  logic [CNT_W-1:0]           total;
  logic                       ovf;
  logic signed [SAMPLE_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                       bin_done;
  logic [CNT_W-1:0]           k;
  logic [ADDR_W-1:0]          clr_idx;
  logic [ADDR_W-1:0]          caddr;
  logic [IDX_W-1:0]           row, col;
  logic                       in_bin;
  logic [23:0]                nx, ny;
  logic [22:0]                dx, dy;
  logic [6:0]                 qx, qy;
  logic [2:0]                 step;
  logic [31:0]                zsq;
  logic [SAMPLE_W-1:0]        zs;
  logic [CNT_W-1:0]           n;
  logic signed [27:0]         sum;
  logic [42:0]                sq;
  logic [OUT_W-1:0]           cx, cy, mean, se;
  logic [34:0]                p_lo;
  logic [33:0]                p_hi;
  logic [55:0]                s2, a_reg, d_reg;
  logic [25:0]                nn;
  logic [38:0]                mden;
  logic [47:0]                sv, sr, sbit;
  logic [4:0]                 scnt;

  logic             o_valid;
  logic [OUT_W-1:0] o_cx, o_cy, o_mean, o_se;
  logic [CNT_W-1:0] o_cnt;
  logic             o_mv, o_sev, o_drop;

  // combinational helpers
  logic [BINS_W-1:0]          bclamp;
  logic [16:0]                span_x, span_y, off_x, off_y;
  logic signed [SAMPLE_W-1:0] sx, sy, sz;
  logic signed [31:0]         zprod;
  logic [23:0]                nx_init, ny_init;
  logic [IDX_W-1:0]           ix, iy;
  logic [12:0]                cprod, qprod;
  logic [27:0]                abs_sum;
  logic [36:0]                mean_num;
  logic [48:0]                rb;
  logic                       sq_ge;
  logic [47:0]                sr_next;
  logic [55:0]                s2_prod;
  logic                       st_we;
  logic                       bin_we;
  logic [ADDR_W-1:0]          bin_waddr;
  logic [12:0]                w_cnt;
  logic [27:0]                w_sum;
  logic [42:0]                w_sq;

  function automatic logic [32:0] center_num(input logic [IDX_W-1:0] idx,
                                             input logic [16:0] span,
                                             input logic [BINS_W-1:0] b);
    logic [23:0] prod;
    prod = {17'b0, idx, 1'b1} * {7'b0, span};
    return {1'b0, prod, 8'b0} + {26'b0, b};
  endfunction

  function automatic logic [OUT_W-1:0] center_sat(input logic signed [SAMPLE_W-1:0] lo,
                                                  input logic [32:0] q);
    logic signed [34:0] s;
    s = $signed({{11{lo[15]}}, lo, 8'b0}) + $signed({2'b0, q});
    if (s > 35'sd8388607) begin
      return 24'h7FFFFF;
    end else if (s < -35'sd8388608) begin
      return 24'h800000;
    end
    return s[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] mean_sat(input logic neg, input logic [36:0] q);
    if (neg) begin
      if (q > 37'd8388608) begin
        return 24'h800000;
      end
      return ~q[OUT_W-1:0] + 24'd1;
    end
    if (q > 37'd8388607) begin
      return 24'h7FFFFF;
    end
    return q[OUT_W-1:0];
  endfunction

  always_comb begin
    if (bins_reg == '0) begin
      bclamp = 7'd1;
    end else if (bins_reg > MAX_BINS) begin
      bclamp = MAX_BINS;
    end else begin
      bclamp = bins_reg;
    end
  end

  assign span_x  = {hi_x[15], hi_x} - {lo_x[15], lo_x};
  assign span_y  = {hi_y[15], hi_y} - {lo_y[15], lo_y};
  assign sx      = $signed(rd_s[47:32]);
  assign sy      = $signed(rd_s[31:16]);
  assign sz      = $signed(rd_s[15:0]);
  assign off_x   = {sx[15], sx} - {lo_x[15], lo_x};
  assign off_y   = {sy[15], sy} - {lo_y[15], lo_y};
  assign nx_init = {7'b0, off_x} * {17'b0, b_used};
  assign ny_init = {7'b0, off_y} * {17'b0, b_used};
  assign zprod   = sz * sz;

  assign ix    = (span_x == '0) ? '0 : ((qx >= b_used) ? IDX_W'(b_used - 1'b1) : qx[5:0]);
  assign iy    = (span_y == '0) ? '0 : ((qy >= b_used) ? IDX_W'(b_used - 1'b1) : qy[5:0]);
  assign cprod = {7'b0, ix} * {6'b0, b_used} + {7'b0, iy};
  assign qprod = {7'b0, row} * {6'b0, b_used} + {7'b0, col};

  assign abs_sum  = sum[27] ? (~sum + 28'd1) : sum;
  assign mean_num = {1'b0, abs_sum, 8'b0} + {25'b0, n[12:1]};
  assign s2_prod  = {28'b0, abs_sum} * {28'b0, abs_sum};

  assign rb      = {1'b0, sr} + {1'b0, sbit};
  assign sq_ge   = ({1'b0, sv} >= rb);
  assign sr_next = sq_ge ? ((sr >> 1) + sbit) : (sr >> 1);

  assign pop   = (state == S_IDLE) && !q_empty;
  assign st_we = pop && (head.op == CMD_LOAD) && !total[12];

  assign bin_we    = (state == S_CLR) || (state == S_SBW);
  assign bin_waddr = (state == S_CLR) ? clr_idx : caddr;
  assign w_cnt     = (state == S_CLR) ? '0 : rd_cnt + 13'd1;
  assign w_sum     = (state == S_CLR) ? '0 : rd_sum + {{12{zs[15]}}, zs};
  assign w_sq      = (state == S_CLR) ? '0 : rd_sq + {11'b0, zsq};

  always_comb begin
    div_req = '0;
    unique case (state)
      S_QDAT: begin
        div_req.start = 1'b1;
        div_req.iters = DIV_CNT_W'(33);
        div_req.num   = {center_num(row, span_x, b_used), 39'b0};
        div_req.den   = {31'b0, b_used, 1'b0};
      end
      S_QCX: begin
        div_req.start = div_rsp.done;
        div_req.iters = DIV_CNT_W'(33);
        div_req.num   = {center_num(col, span_y, b_used), 39'b0};
        div_req.den   = {31'b0, b_used, 1'b0};
      end
      S_QCY: begin
        div_req.start = div_rsp.done && (n != '0);
        div_req.iters = DIV_CNT_W'(37);
        div_req.num   = {mean_num, 35'b0};
        div_req.den   = {26'b0, n};
      end
      S_QM5: begin
        div_req.start = 1'b1;
        div_req.iters = DIV_CNT_W'(72);
        div_req.num   = {d_reg, 16'b0};
        div_req.den   = mden;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[total[ADDR_W-1:0]] <= {head.x, head.y, head.z};
    end
    rd_s <= store_mem[k[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      cnt_mem[bin_waddr] <= w_cnt;
      sum_mem[bin_waddr] <= w_sum;
      sq_mem[bin_waddr]  <= w_sq;
    end
    rd_cnt <= cnt_mem[caddr];
    rd_sum <= sum_mem[caddr];
    rd_sq  <= sq_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bins_reg <= BINS_RESET;
      b_used   <= 7'd1;
      total    <= '0;
      ovf      <= 1'b0;
      lo_x     <= '0;
      hi_x     <= '0;
      lo_y     <= '0;
      hi_y     <= '0;
      bin_done <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (o_valid && rsp.ready && (state != S_QOUT)) begin
        o_valid <= 1'b0;
      end
      if (cfg_we) begin
        bins_reg <= cfg_data;
        bin_done <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (head.op)
              CMD_LOAD: begin
                bin_done <= 1'b0;
                if (total[12]) begin
                  ovf <= 1'b1;
                end else begin
                  total <= total + 1'b1;
                  if (total == '0) begin
                    lo_x <= $signed(head.x);
                    hi_x <= $signed(head.x);
                    lo_y <= $signed(head.y);
                    hi_y <= $signed(head.y);
                  end else begin
                    if ($signed(head.x) < lo_x) lo_x <= $signed(head.x);
                    if ($signed(head.x) > hi_x) hi_x <= $signed(head.x);
                    if ($signed(head.y) < lo_y) lo_y <= $signed(head.y);
                    if ($signed(head.y) > hi_y) hi_y <= $signed(head.y);
                  end
                end
              end
              CMD_CLEAR: begin
                total    <= '0;
                ovf      <= 1'b0;
                lo_x     <= '0;
                hi_x     <= '0;
                lo_y     <= '0;
                hi_y     <= '0;
                bin_done <= 1'b0;
              end
              CMD_QUERY: begin
                row   <= head.row;
                col   <= head.col;
                state <= bin_done ? S_QADDR : S_BINIT;
              end
              default: ;
            endcase
          end
        end
        S_BINIT: begin
          b_used  <= bclamp;
          bb      <= {6'b0, bclamp} * {6'b0, bclamp};
          clr_idx <= '0;
          state   <= S_CLR;
        end
        S_CLR: begin
          if ({1'b0, clr_idx} == bb - 1'b1) begin
            k     <= '0;
            state <= S_SRD;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_SRD: begin
          if (k == total) begin
            bin_done <= 1'b1;
            state    <= S_QADDR;
          end else begin
            state <= S_SOFF;
          end
        end
        S_SOFF: begin
          nx    <= nx_init;
          ny    <= ny_init;
          dx    <= {span_x, 6'b0};
          dy    <= {span_y, 6'b0};
          qx    <= '0;
          qy    <= '0;
          step  <= '0;
          zsq   <= zprod;
          zs    <= sz;
          state <= S_SDIV;
        end
        S_SDIV: begin
          if (nx >= {1'b0, dx}) begin
            nx <= nx - {1'b0, dx};
            qx <= {qx[5:0], 1'b1};
          end else begin
            qx <= {qx[5:0], 1'b0};
          end
          if (ny >= {1'b0, dy}) begin
            ny <= ny - {1'b0, dy};
            qy <= {qy[5:0], 1'b1};
          end else begin
            qy <= {qy[5:0], 1'b0};
          end
          dx   <= dx >> 1;
          dy   <= dy >> 1;
          step <= step + 1'b1;
          if (step == 3'd6) begin
            state <= S_SIDX;
          end
        end
        S_SIDX: begin
          caddr <= cprod[ADDR_W-1:0];
          state <= S_SBR;
        end
        S_SBR: begin
          state <= S_SBW;
        end
        S_SBW: begin
          k     <= k + 1'b1;
          state <= S_SRD;
        end
        S_QADDR: begin
          in_bin <= ({1'b0, row} < b_used) && ({1'b0, col} < b_used);
          caddr  <= qprod[ADDR_W-1:0];
          state  <= S_QRD;
        end
        S_QRD: begin
          state <= S_QDAT;
        end
        S_QDAT: begin
          n     <= in_bin ? rd_cnt : '0;
          sum   <= in_bin ? $signed(rd_sum) : '0;
          sq    <= in_bin ? rd_sq : '0;
          state <= S_QCX;
        end
        S_QCX: begin
          if (div_rsp.done) begin
            cx    <= center_sat(lo_x, div_rsp.quo[32:0]);
            state <= S_QCY;
          end
        end
        S_QCY: begin
          if (div_rsp.done) begin
            cy <= center_sat(lo_y, div_rsp.quo[32:0]);
            if (n != '0) begin
              state <= S_QMEAN;
            end else begin
              mean  <= '0;
              se    <= '0;
              state <= S_QOUT;
            end
          end
        end
        S_QMEAN: begin
          if (div_rsp.done) begin
            mean <= mean_sat(sum[27], div_rsp.quo[36:0]);
            if (n > 13'd1) begin
              state <= S_QM1;
            end else begin
              se    <= '0;
              state <= S_QOUT;
            end
          end
        end
        S_QM1: begin
          p_lo  <= {22'b0, n} * {13'b0, sq[21:0]};
          s2    <= s2_prod;
          nn    <= {13'b0, n} * {13'b0, n};
          state <= S_QM2;
        end
        S_QM2: begin
          p_hi  <= {21'b0, n} * {13'b0, sq[42:22]};
          mden  <= {13'b0, nn} * {26'b0, n - 13'd1};
          state <= S_QM3;
        end
        S_QM3: begin
          a_reg <= {21'b0, p_lo} + {p_hi, 22'b0};
          state <= S_QM4;
        end
        S_QM4: begin
          d_reg <= (a_reg > s2) ? (a_reg - s2) : '0;
          state <= S_QM5;
        end
        S_QM5: begin
          state <= S_QSE;
        end
        S_QSE: begin
          if (div_rsp.done) begin
            sv    <= div_rsp.quo[47:0];
            sr    <= '0;
            sbit  <= 48'h4000_0000_0000;
            scnt  <= '0;
            state <= S_QSQ;
          end
        end
        S_QSQ: begin
          if (sq_ge) begin
            sv <= sv - rb[47:0];
          end
          sr   <= sr_next;
          sbit <= sbit >> 2;
          scnt <= scnt + 1'b1;
          if (scnt == 5'd23) begin
            se    <= sr_next[OUT_W-1:0];
            state <= S_QOUT;
          end
        end
        S_QOUT: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_cx    <= cx;
            o_cy    <= cy;
            o_cnt   <= n;
            o_mean  <= mean;
            o_mv    <= (n != '0);
            o_se    <= se;
            o_sev   <= (n > 13'd1);
            o_drop  <= ovf;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid           = o_valid;
  assign rsp.center_x        = o_cx;
  assign rsp.center_y        = o_cy;
  assign rsp.entry_count     = o_cnt;
  assign rsp.mean_z          = o_mean;
  assign rsp.mean_valid      = o_mv;
  assign rsp.std_error       = o_se;
  assign rsp.std_error_valid = o_sev;
  assign rsp.samples_dropped = o_drop;

endmodule

// ===== sv/binned_2d_mean_stderr.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - top level
// Loads and clears are handled in the execution unit's idle state; requests
// queue 4 deep. A query uses the shared bit-serial divider (33 + 33 + 37 + 72
// steps) and a 24-step square root; the last two only for two or more samples.
// A query after a load, clear or bins write first rebins all stored samples.
// Synchronous reset clears control state only; no clearing sweep after reset.
// ----------------------------------------------------------------------------
module binned_2d_mean_stderr import b2ms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  b2ms_cfg_if.sink   cfg,
  b2ms_req_if.sink   req,
  b2ms_rsp_if.source rsp
);

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  entry_t   push_entry;
  entry_t   head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;

  b2ms_front u_front (
    .req        (req),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b2ms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  b2ms_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  b2ms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.bins_per_dim),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .rsp      (rsp)
  );

endmodule

// ===== sv/b2ms_checker.sv =====
// ----------------------------------------------------------------------------
// Binned 2D mean statistics - port checker
// Checks response consistency and stall behaviour at the top-level ports.
// ----------------------------------------------------------------------------
`include "binned_2d_mean_stderr_defines.svh"

module b2ms_checker import b2ms_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [OUT_W-1:0] center_x,
  input logic [CNT_W-1:0] entry_count,
  input logic [OUT_W-1:0] mean_z,
  input logic             mean_valid,
  input logic [OUT_W-1:0] std_error,
  input logic             std_error_valid
);

  `B2MS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(center_x) && $stable(mean_z) && $stable(entry_count), "response changed while stalled")
  `B2MS_ASSERT_NOW(a_flags, rsp_valid, (mean_valid == (entry_count != 0)) && (std_error_valid == (entry_count > 1)), "validity flags disagree with count")
  `B2MS_ASSERT_NOW(a_empty_zero, rsp_valid && !mean_valid, (mean_z == 0) && (std_error == 0), "empty bin with non-zero statistics")
  `B2MS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind binned_2d_mean_stderr b2ms_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .center_x        (rsp.center_x),
  .entry_count     (rsp.entry_count),
  .mean_z          (rsp.mean_z),
  .mean_valid      (rsp.mean_valid),
  .std_error       (rsp.std_error),
  .std_error_valid (rsp.std_error_valid)
);
